// ----- rtl/core/tevq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tevq_pkg
// Shared types and codes for the timed event queue core.
// ----------------------------------------------------------------------------
package tevq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 16;
  localparam int MAX_RUN      = 16;   // releases per tick at most

  localparam int TAG_W  = 16;         // tag field width on the ports
  localparam int TIME_W = 32;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_DUE    = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic ins;   // sorted insert of the new entry
    logic pop;   // shift toward the head by one
  } cell_ctl_t;

endpackage

// ----- rtl/core/timed_event_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue_core
// Sorted timer queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : requests. in_tuser = func (0 add, 1 tick). in_tdata = tag, time.
//   out_* : results. out_tuser = kind, out_tlast = last of the request.
//   cfg_* : run_enable write, always ready.
// In an add, every cell compares its due time with
// the new one at once and either holds, takes the new entry or takes its
// neighbor's. Its status result is registered the cycle after acceptance.
// A tick with due tasks releases one task per cycle from the head cell
// while the output is not stalled, the row shifting toward the head with
// each release, up to MAX_RUN tasks; a tick with nothing due or with
// releases stopped gives no result. A new request is taken only in the
// idle state and when the output register is empty or being read, so an
// output stall holds the release run in place.
// Reset empties the queue and sets run_enable to 1; no clearing pass.
// ----------------------------------------------------------------------------
module timed_event_queue_core #(
  parameter int DEPTH    = tevq_pkg::DEPTH_DEF,
  parameter int TAG_BITS = tevq_pkg::TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] task_tag, [47:16] time_value
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] fired_tag, [47:16] fired_due
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RUN_W = $clog2(tevq_pkg::MAX_RUN);
  localparam int TW    = tevq_pkg::TIME_W;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [RUN_W-1:0] n_r, n_nxt;
  logic [TW-1:0]    tval_r, tval_nxt;
  logic             run_en_r;
  tevq_pkg::state_t st_r, st_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r, out_kind_nxt;
  logic [15:0]      out_tag_r, out_tag_nxt;
  logic [TW-1:0]    out_due_r, out_due_nxt;
  logic             out_last_r, out_last_nxt;

  tevq_pkg::cell_ctl_t ctl;
  logic [TW-1:0]       due_q [DEPTH];
  logic [TAG_BITS-1:0] tag_q [DEPTH];
  logic                keep  [DEPTH];
  logic                occ   [DEPTH];

  logic [TAG_BITS-1:0] tag_in;
  logic [15:0]         head_tag16;
  logic [TW-1:0]       in_time;
  logic                slot_free, acc, is_tick, full, head_due_now, pop_last;

  assign in_time = in_tdata[47:16];

  always_comb begin
    tag_in = '0;
    for (int b = 0; b < TAG_BITS && b < 16; b++) tag_in[b] = in_tdata[b];
  end

  always_comb begin
    head_tag16 = '0;
    for (int b = 0; b < TAG_BITS && b < 16; b++) head_tag16[b] = tag_q[0][b];
  end

  // ---- cell row ----
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count_r);
    tevq_cell #(.TAG_BITS(TAG_BITS)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occ      (occ[i]),
      .new_due  (in_time),
      .new_tag  (tag_in),
      .left_keep((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
      .left_due (due_q[(i == 0) ? 0 : i - 1]),
      .left_tag (tag_q[(i == 0) ? 0 : i - 1]),
      .right_due(due_q[(i == DEPTH - 1) ? i : i + 1]),
      .right_tag(tag_q[(i == DEPTH - 1) ? i : i + 1]),
      .keep     (keep[i]),
      .due      (due_q[i]),
      .tag      (tag_q[i])
    );
  end

  // ---- control ----
  assign slot_free    = !out_valid_r || out_tready;
  assign in_tready    = (st_r == tevq_pkg::ST_IDLE) && slot_free;
  assign acc          = in_tvalid && in_tready;
  assign is_tick      = (in_tuser == tevq_pkg::FUNC_TICK);
  assign full         = (count_r == CNT_W'(DEPTH));
  assign head_due_now = (count_r != '0) && (due_q[0] <= in_time);
  assign pop_last     = !((count_r > CNT_W'(1)) && (due_q[1] <= tval_r) &&
                          (n_r < RUN_W'(tevq_pkg::MAX_RUN - 1)));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      tevq_pkg::ST_IDLE: begin
        if (acc && is_tick && run_en_r && head_due_now) st_nxt = tevq_pkg::ST_POP;
      end
      tevq_pkg::ST_POP: begin
        if (slot_free && pop_last) st_nxt = tevq_pkg::ST_IDLE;
      end
      default: st_nxt = tevq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    count_nxt     = count_r;
    n_nxt         = n_r;
    tval_nxt      = tval_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_tag_nxt   = out_tag_r;
    out_due_nxt   = out_due_r;
    out_last_nxt  = out_last_r;
    unique case (st_r)
      tevq_pkg::ST_IDLE: begin
        if (acc) begin
          if (is_tick) begin
            tval_nxt = in_time;
            n_nxt    = '0;
          end else begin
            out_valid_nxt = 1'b1;
            out_tag_nxt   = '0;
            out_due_nxt   = '0;
            out_last_nxt  = 1'b1;
            if (full) begin
              out_kind_nxt = tevq_pkg::KIND_REJECT;
            end else begin
              out_kind_nxt = tevq_pkg::KIND_ACCEPT;
              ctl.ins      = 1'b1;
              count_nxt    = count_r + CNT_W'(1);
            end
          end
        end
      end
      tevq_pkg::ST_POP: begin
        if (slot_free) begin
          ctl.pop       = 1'b1;
          count_nxt     = count_r - CNT_W'(1);
          n_nxt         = n_r + RUN_W'(1);
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tevq_pkg::KIND_DUE;
          out_tag_nxt   = head_tag16;
          out_due_nxt   = due_q[0];
          out_last_nxt  = pop_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= tevq_pkg::ST_IDLE;
      count_r     <= '0;
      n_r         <= '0;
      run_en_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) run_en_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    tval_r     <= tval_nxt;
    out_kind_r <= out_kind_nxt;
    out_tag_r  <= out_tag_nxt;
    out_due_r  <= out_due_nxt;
    out_last_r <= out_last_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_due_r, out_tag_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == tevq_pkg::ST_POP |-> count_r != '0)
    else $error("release run on empty queue");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !is_tick && full |=> out_tvalid && out_tuser == tevq_pkg::KIND_REJECT)
    else $error("add on full queue not rejected");

  a_due_in_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tevq_pkg::KIND_DUE |-> out_tdata[47:16] <= tval_r)
    else $error("released task not yet due");

endmodule

// ----- rtl/core/tevq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tevq_cell
// One slot of the sorted row: holds a due time and a tag.
// ----------------------------------------------------------------------------
module tevq_cell #(
  parameter int TAG_BITS = tevq_pkg::TAG_BITS_DEF
) (
  input  logic                        clk,
  input  tevq_pkg::cell_ctl_t         ctl,
  input  logic                        occ,       // slot holds a live entry
  input  logic [tevq_pkg::TIME_W-1:0] new_due,
  input  logic [TAG_BITS-1:0]         new_tag,
  input  logic                        left_keep, // neighbor toward head keeps
  input  logic [tevq_pkg::TIME_W-1:0] left_due,
  input  logic [TAG_BITS-1:0]         left_tag,
  input  logic [tevq_pkg::TIME_W-1:0] right_due,
  input  logic [TAG_BITS-1:0]         right_tag,
  output logic                        keep,
  output logic [tevq_pkg::TIME_W-1:0] due,
  output logic [TAG_BITS-1:0]         tag
);

  logic [tevq_pkg::TIME_W-1:0] due_r, due_nxt;
  logic [TAG_BITS-1:0]         tag_r, tag_nxt;

  // equal due times stay ahead of the new entry
  assign keep = occ && (due_r <= new_due);

  always_comb begin
    due_nxt = due_r;
    tag_nxt = tag_r;
    priority if (ctl.ins) begin
      if (!keep) begin
        if (left_keep) begin
          due_nxt = new_due;
          tag_nxt = new_tag;
        end else begin
          due_nxt = left_due;
          tag_nxt = left_tag;
        end
      end
    end else if (ctl.pop) begin
      due_nxt = right_due;
      tag_nxt = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    due_r <= due_nxt;
    tag_r <= tag_nxt;
  end

  assign due = due_r;
  assign tag = tag_r;

endmodule
